[design/b32e_pkg.sv]
// ----------------------------------------------------------------------------
// b32e_pkg
// Shared types, constants and the symbol table of the base32 byte encoder.
// ----------------------------------------------------------------------------
package b32e_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned GROUP_W    = 5;
  localparam int unsigned PEND_W     = 4;
  localparam int unsigned PCNT_W     = 3;
  localparam int unsigned ACC_W      = PEND_W + BYTE_W;
  // Up to three 5-bit groups are produced by one input byte.
  localparam int unsigned GROUPS_W   = 3 * GROUP_W;
  localparam int unsigned NCHAR_W    = 2;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // Group index codes within one queue entry.
  localparam logic [1:0] GRP_FIRST  = 2'd0;
  localparam logic [1:0] GRP_SECOND = 2'd1;
  localparam logic [1:0] GRP_THIRD  = 2'd2;

  // One queue entry: the left-aligned groups of one byte, the number of
  // characters to emit (1 to 3) and whether the last of them ends the message.
  typedef struct packed {
    logic [GROUPS_W-1:0] groups;
    logic [NCHAR_W-1:0]  nchar;
    logic                eom;
  } entry_t;

  // Alphabet: a..z without l and o, then 2..9.
  function automatic logic [BYTE_W-1:0] symbol_of(input logic [GROUP_W-1:0] grp);
    logic [BYTE_W-1:0] c;
    c = 8'h61;
    case (grp)
      5'd0:    c = 8'h61;  // a
      5'd1:    c = 8'h62;
      5'd2:    c = 8'h63;
      5'd3:    c = 8'h64;
      5'd4:    c = 8'h65;
      5'd5:    c = 8'h66;
      5'd6:    c = 8'h67;
      5'd7:    c = 8'h68;
      5'd8:    c = 8'h69;  // i
      5'd9:    c = 8'h6a;
      5'd10:   c = 8'h6b;
      5'd11:   c = 8'h6d;  // m
      5'd12:   c = 8'h6e;
      5'd13:   c = 8'h70;  // p
      5'd14:   c = 8'h71;
      5'd15:   c = 8'h72;
      5'd16:   c = 8'h73;
      5'd17:   c = 8'h74;
      5'd18:   c = 8'h75;
      5'd19:   c = 8'h76;
      5'd20:   c = 8'h77;
      5'd21:   c = 8'h78;
      5'd22:   c = 8'h79;
      5'd23:   c = 8'h7a;  // z
      5'd24:   c = 8'h32;  // 2
      5'd25:   c = 8'h33;
      5'd26:   c = 8'h34;
      5'd27:   c = 8'h35;
      5'd28:   c = 8'h36;
      5'd29:   c = 8'h37;
      5'd30:   c = 8'h38;
      5'd31:   c = 8'h39;  // 9
      default: c = 8'h61;
    endcase
    return c;
  endfunction

endpackage

[design/b32e_front.sv]
// ----------------------------------------------------------------------------
// b32e_front
// Accepts bytes, merges them with the leftover bits and splits the result
// into 5-bit groups for the character queue.
// ----------------------------------------------------------------------------
module b32e_front import b32e_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              in_eom,
  output logic              push_valid,
  input  logic              push_ready,
  output entry_t            push_entry
);

  logic [PEND_W-1:0] pending_bits, pending_bits_next;
  logic [PCNT_W-1:0] pending_count, pending_count_next;

  logic [ACC_W-1:0]    acc;
  logic [3:0]          total;
  logic                two_full;
  logic [PCNT_W-1:0]   rem;
  logic [2:0]          shift;
  logic [GROUPS_W-1:0] aligned;
  logic [PEND_W-1:0]   rem_mask;
  logic                flush;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;

  always_comb begin
    acc      = {pending_bits, in_byte};
    total    = 4'(pending_count) + 4'd8;
    two_full = (total >= 4'd10);
    rem      = two_full ? PCNT_W'(total - 4'd10) : PCNT_W'(total - 4'd5);
    shift    = 3'(4'd15 - total);
    // Left-align the valid bits so groups sit at fixed places, zero padded.
    aligned  = GROUPS_W'({3'b000, acc}) << shift;
    rem_mask = PEND_W'((5'd1 << rem) - 5'd1);
    flush    = in_eom && (rem != '0);

    push_entry.groups = aligned;
    push_entry.nchar  = (two_full ? 2'd2 : 2'd1) + {1'b0, flush};
    push_entry.eom    = in_eom;

    if (in_eom) begin
      pending_bits_next  = '0;
      pending_count_next = '0;
    end else begin
      pending_bits_next  = acc[PEND_W-1:0] & rem_mask;
      pending_count_next = rem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bits  <= '0;
      pending_count <= '0;
    end else if (in_valid && in_ready) begin
      pending_bits  <= pending_bits_next;
      pending_count <= pending_count_next;
    end
  end

endmodule

[design/b32e_queue.sv]
// ----------------------------------------------------------------------------
// b32e_queue
// Small register FIFO of group entries between the front and back parts.
// ----------------------------------------------------------------------------
module b32e_queue import b32e_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push_valid,
  output logic   push_ready,
  input  entry_t push_entry,
  output logic   pop_valid,
  input  logic   pop_ready,
  output entry_t pop_entry
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  entry_t            slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  fill;
  logic              do_push, do_pop;

  assign push_ready = (fill != CNT_W'(DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_entry  = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

[design/b32e_back.sv]
// ----------------------------------------------------------------------------
// b32e_back
// Walks the groups of the head entry, one character per cycle while the
// output is not stalled, into the output register.
// ----------------------------------------------------------------------------
module b32e_back import b32e_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  entry_t            pop_entry,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] out_char,
  output logic              out_last
);

  logic [1:0]         idx;
  logic [1:0]         last_idx;
  logic               advance;
  logic               at_end;
  logic [GROUP_W-1:0] grp;

  always_comb begin
    last_idx = pop_entry.nchar - 2'd1;
    at_end   = (idx == last_idx);
    advance  = pop_valid && (!out_valid || out_ready);
    case (idx)
      GRP_FIRST:  grp = pop_entry.groups[3*GROUP_W-1:2*GROUP_W];
      GRP_SECOND: grp = pop_entry.groups[2*GROUP_W-1:GROUP_W];
      GRP_THIRD:  grp = pop_entry.groups[GROUP_W-1:0];
      default:    grp = pop_entry.groups[GROUP_W-1:0];
    endcase
  end

  assign pop_ready = advance && at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= GRP_FIRST;
      out_valid <= 1'b0;
    end else if (advance) begin
      idx       <= at_end ? GRP_FIRST : idx + 2'd1;
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_char <= symbol_of(grp);
      out_last <= pop_entry.eom && at_end;
    end
  end

endmodule

[design/base32_byte_encoder.sv]
// ----------------------------------------------------------------------------
// base32_byte_encoder
// Streaming base32 encoder, one byte in, 5-bit groups out as ASCII characters.
// ----------------------------------------------------------------------------
// Each byte taken on the slave side is appended to the up to four bits left
// over from the previous byte, and every complete 5-bit group, most
// significant bits first, leaves on the master side as one ASCII character
// of the alphabet a..z without l and o, followed by 2..9. When s_tlast marks
// the final byte, the remaining bits are padded with zeros to a full group,
// no '=' padding is added, and the last character carries m_tlast; the next
// byte then starts a new message. A byte makes one to three characters and
// the back part emits one character per cycle while the master side does
// not stall. The front part takes a byte whenever the queue has room and
// files its groups into a small queue; the output register is refilled in
// the same cycle it is taken, so both sides can stall on their own.
// The first character of a byte passes through the queue and then the
// output register before it is offered on the master side.
// ----------------------------------------------------------------------------
module base32_byte_encoder import b32e_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tlast,   // end_of_message
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] symbol_char
  output logic       m_tlast    // final_symbol
);

  // Front to queue.
  logic   push_valid, push_ready;
  entry_t push_entry;
  // Queue to back.
  logic   pop_valid, pop_ready;
  entry_t pop_entry;

  // The front computes all groups of a byte combinationally from the leftover
  // bits it holds; a byte is accepted whenever the queue has room.
  b32e_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_byte    (s_tdata),
    .in_eom     (s_tlast),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  b32e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  // The back releases a queue entry together with its last character.
  b32e_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_entry (pop_entry),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_char  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

[design/b32e_checker.sv]
// ----------------------------------------------------------------------------
// b32e_checker
// Port-level checks of the base32 byte encoder, bound to the top level.
// ----------------------------------------------------------------------------
module b32e_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);

  logic legal_char;

  assign legal_char = ((m_tdata >= 8'h61) && (m_tdata <= 8'h7a) &&
                       (m_tdata != 8'h6c) && (m_tdata != 8'h6f)) ||
                      ((m_tdata >= 8'h32) && (m_tdata <= 8'h39));

  // A held character does not change while it waits.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output transaction changed while stalled");

  // Every character comes from the alphabet.
  a_alpha: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> legal_char)
    else $error("character outside the alphabet");

  // Reset empties the output register.
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  // Nothing can come out in the cycle after reset unless a byte went in.
  a_cause: assert property (@(posedge clk) disable iff (rst)
    $past(rst) && !$past(s_tvalid && s_tready) |-> !m_tvalid)
    else $error("character appeared without any input transaction");

endmodule

bind base32_byte_encoder b32e_checker u_b32e_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
